>>> rtl/core/rbsi_pkg.sv
// Shared types and constants for the ray/box slab intersection pipeline.
// No dependencies; ray_box_slab_intersect refers to this package, rbsi_div does not.
package rbsi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  // Quotient bits resolved per divider pipeline stage.
  localparam int DIV_BITS    = 4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
  } rbsi_in_t;

  typedef struct packed {
    logic   hit;
    logic   starts_inside;
    coord_t entry_distance;
    coord_t exit_distance;
  } rbsi_out_t;

  // Per-axis status that rides alongside the divider pipeline.
  typedef struct packed {
    logic in_slab;
    logic inverted;
    logic dir_zero;
  } axis_flag_t;

endpackage

>>> rtl/core/ray_box_slab_intersect.sv
// Ray against axis-aligned box, slab test, signed fixed point, one transaction per cycle unless stalled.
// Pipeline: input register, divider (4 quotient bits per stage), near/far, entry/exit and output registers.
// Throughput: one transaction per cycle while the output is taken; the divider stages set the depth, not the rate.
// The whole pipeline holds while the output register is full and not taken.
// Reset (rst_ni low, asynchronous) clears all valid bits; data registers are not reset.
// Depends on rbsi_pkg and rbsi_div.
module ray_box_slab_intersect #(
  parameter int FracBits = rbsi_pkg::FRAC_BITS,
  parameter int DivBits  = rbsi_pkg::DIV_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rbsi_pkg::rbsi_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rbsi_pkg::rbsi_out_t out_data_o
);

  localparam int W         = rbsi_pkg::COORD_WIDTH;
  localparam int NumStages = (W + DivBits - 1) / DivBits;
  localparam int DivLat    = NumStages + 2;
  localparam int Lat       = DivLat + 4;

  localparam logic signed [W-1:0] MinVal = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] MaxVal = {1'b0, {(W-1){1'b1}}};

  logic           en;
  logic [Lat-1:0] vld_q;

  assign en          = !vld_q[Lat-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  rbsi_pkg::coord_t org [3];
  rbsi_pkg::coord_t dir [3];
  rbsi_pkg::coord_t bmin [3];
  rbsi_pkg::coord_t bmax [3];

  always_comb begin
    org[0]  = in_data_i.origin_x;
    org[1]  = in_data_i.origin_y;
    org[2]  = in_data_i.origin_z;
    dir[0]  = in_data_i.dir_x;
    dir[1]  = in_data_i.dir_y;
    dir[2]  = in_data_i.dir_z;
    bmin[0] = in_data_i.box_min_x;
    bmin[1] = in_data_i.box_min_y;
    bmin[2] = in_data_i.box_min_z;
    bmax[0] = in_data_i.box_max_x;
    bmax[1] = in_data_i.box_max_y;
    bmax[2] = in_data_i.box_max_z;
  end

  rbsi_pkg::axis_flag_t [2:0] flg_q [DivLat+1];
  rbsi_pkg::coord_t           t_lo  [3];
  rbsi_pkg::coord_t           t_hi  [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [W:0] dlo;
    logic signed [W:0] dhi;
    logic [W:0]        dlo_abs;
    logic [W:0]        dhi_abs;
    logic [W-1:0]      dmag_d;
    logic              dneg;
    logic [W-1:0]      mag_lo_q;
    logic [W-1:0]      mag_hi_q;
    logic [W-1:0]      dmag_q;
    logic              neg_lo_q;
    logic              neg_hi_q;

    assign dlo     = {bmin[a][W-1], bmin[a]} - {org[a][W-1], org[a]};
    assign dhi     = {bmax[a][W-1], bmax[a]} - {org[a][W-1], org[a]};
    assign dlo_abs = dlo[W] ? (~dlo + 1'b1) : dlo;
    assign dhi_abs = dhi[W] ? (~dhi + 1'b1) : dhi;
    assign dneg    = dir[a][W-1];
    assign dmag_d  = dneg ? (~dir[a] + 1'b1) : dir[a];

    always_ff @(posedge clk_i) begin
      if (en) begin
        mag_lo_q           <= dlo_abs[W-1:0];
        mag_hi_q           <= dhi_abs[W-1:0];
        dmag_q             <= dmag_d;
        neg_lo_q           <= dlo[W] ^ dneg;
        neg_hi_q           <= dhi[W] ^ dneg;
        flg_q[0][a].in_slab  <= !(org[a] < bmin[a]) && !(bmax[a] < org[a]);
        flg_q[0][a].inverted <= bmax[a] < bmin[a];
        flg_q[0][a].dir_zero <= dir[a] == '0;
      end
    end

    rbsi_div #(
      .Width    (W),
      .FracBits (FracBits),
      .StepBits (DivBits)
    ) u_div_lo (
      .clk_i     (clk_i),
      .en_i      (en),
      .num_mag_i (mag_lo_q),
      .den_mag_i (dmag_q),
      .neg_i     (neg_lo_q),
      .quot_o    (t_lo[a])
    );

    rbsi_div #(
      .Width    (W),
      .FracBits (FracBits),
      .StepBits (DivBits)
    ) u_div_hi (
      .clk_i     (clk_i),
      .en_i      (en),
      .num_mag_i (mag_hi_q),
      .den_mag_i (dmag_q),
      .neg_i     (neg_hi_q),
      .quot_o    (t_hi[a])
    );
  end

  // Carry the axis flags alongside the divider.
  for (genvar i = 1; i <= DivLat; i++) begin : g_flag_dly
    always_ff @(posedge clk_i) begin
      if (en) begin
        flg_q[i] <= flg_q[i-1];
      end
    end
  end

  // Near/far per axis; an axis that sets no bound contributes neutral values.
  rbsi_pkg::coord_t nr_q [3];
  rbsi_pkg::coord_t fr_q [3];
  logic             excl_c1_q;
  logic             inside_c1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        if (flg_q[DivLat][a].inverted || flg_q[DivLat][a].dir_zero) begin
          nr_q[a] <= MinVal;
          fr_q[a] <= MaxVal;
        end else if (t_hi[a] < t_lo[a]) begin
          nr_q[a] <= t_hi[a];
          fr_q[a] <= t_lo[a];
        end else begin
          nr_q[a] <= t_lo[a];
          fr_q[a] <= t_hi[a];
        end
      end
      excl_c1_q <= (flg_q[DivLat][0].inverted ||
                    (flg_q[DivLat][0].dir_zero && !flg_q[DivLat][0].in_slab)) ||
                   (flg_q[DivLat][1].inverted ||
                    (flg_q[DivLat][1].dir_zero && !flg_q[DivLat][1].in_slab)) ||
                   (flg_q[DivLat][2].inverted ||
                    (flg_q[DivLat][2].dir_zero && !flg_q[DivLat][2].in_slab));
      inside_c1_q <= flg_q[DivLat][0].in_slab && flg_q[DivLat][1].in_slab &&
                     flg_q[DivLat][2].in_slab;
    end
  end

  // Entry is the largest near distance (zero if the origin is inside), exit the smallest far distance.
  rbsi_pkg::coord_t entry_d;
  rbsi_pkg::coord_t exit_d;
  rbsi_pkg::coord_t entry_q;
  rbsi_pkg::coord_t exit_q;
  logic             excl_c2_q;
  logic             inside_c2_q;

  always_comb begin
    entry_d = nr_q[0];
    exit_d  = fr_q[0];
    for (int a = 1; a < 3; a++) begin
      if (entry_d < nr_q[a]) begin
        entry_d = nr_q[a];
      end
      if (fr_q[a] < exit_d) begin
        exit_d = fr_q[a];
      end
    end
    if (inside_c1_q) begin
      entry_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      entry_q     <= entry_d;
      exit_q      <= exit_d;
      excl_c2_q   <= excl_c1_q;
      inside_c2_q <= inside_c1_q;
    end
  end

  rbsi_pkg::rbsi_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.hit            <= !excl_c2_q && !(exit_q < entry_q) && !exit_q[W-1];
      out_q.starts_inside  <= inside_c2_q;
      out_q.entry_distance <= entry_q;
      out_q.exit_distance  <= exit_q;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> rtl/core/rbsi_div.sv
// Pipelined saturating fixed-point divider: (num << FracBits) / den, sign applied last.
// Uses no package items; instantiated six times by ray_box_slab_intersect.
module rbsi_div #(
  parameter int Width    = 32,
  parameter int FracBits = 16,
  parameter int StepBits = 4
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [Width-1:0]        num_mag_i,
  input  logic [Width-1:0]        den_mag_i,
  input  logic                    neg_i,
  output logic signed [Width-1:0] quot_o
);

  localparam int NumStages = (Width + StepBits - 1) / StepBits;
  localparam int NumW      = Width + FracBits;

  logic [NumW-1:0] num_full;
  logic [NumW-1:0] num_hi;
  logic            ovf_d;

  assign num_full = {num_mag_i, {FracBits{1'b0}}};
  assign num_hi   = num_full >> Width;
  // Quotient needs more than Width bits: saturate.
  assign ovf_d    = num_hi >= NumW'(den_mag_i);

  logic [Width-1:0] rem_q [NumStages];
  logic [Width-1:0] qd_q  [NumStages+1];
  logic [Width-1:0] den_q [NumStages];
  logic             ovf_q [NumStages+1];
  logic             neg_q [NumStages+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_hi[Width-1:0];
      qd_q[0]  <= num_full[Width-1:0];
      den_q[0] <= den_mag_i;
      ovf_q[0] <= ovf_d;
      neg_q[0] <= neg_i;
    end
  end

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    logic [Width-1:0] rem_d;
    logic [Width-1:0] qd_d;

    // Restoring division: dividend bits leave qd at the top, quotient bits enter at the bottom.
    always_comb begin : p_step
      logic [Width-1:0] r;
      logic [Width-1:0] qd;
      logic [Width:0]   r2;
      r  = rem_q[s];
      qd = qd_q[s];
      r2 = '0;
      for (int j = 0; j < StepBits; j++) begin
        if (s * StepBits + j < Width) begin
          r2 = {r, qd[Width-1]};
          qd = {qd[Width-2:0], 1'b0};
          if (r2 >= {1'b0, den_q[s]}) begin
            r2    = r2 - {1'b0, den_q[s]};
            qd[0] = 1'b1;
          end
          r = r2[Width-1:0];
        end
      end
      rem_d = r;
      qd_d  = qd;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qd_q[s+1]  <= qd_d;
        ovf_q[s+1] <= ovf_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end

    if (s < NumStages - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s+1] <= rem_d;
          den_q[s+1] <= den_q[s];
        end
      end
    end
  end

  logic [Width-1:0] limit;
  logic [Width-1:0] q_sat;
  logic             sat;
  logic [Width-1:0] quot_q;

  assign limit = {neg_q[NumStages], {(Width-1){~neg_q[NumStages]}}};
  assign sat   = ovf_q[NumStages] || (qd_q[NumStages] > limit);
  assign q_sat = sat ? limit : qd_q[NumStages];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= neg_q[NumStages] ? (~q_sat + 1'b1) : q_sat;
    end
  end

  assign quot_o = $signed(quot_q);

endmodule
